[rtl/core/ccst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccst_pkg: coin/credit service tick shared definitions
// Payload types, coinage table, register indexes and credit helpers.
// ----------------------------------------------------------------------------
package ccst_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEBOUNCE_TICKS_DEF = 5;
  localparam int unsigned METER_PERIOD_DEF   = 50;

  // Fixed widths
  localparam int unsigned DEB_W     = 3;   // debounce count, up to 7 ticks
  localparam int unsigned TMR_W     = 6;   // meter timer, up to 63 ticks
  localparam int unsigned QUEUE_W   = 8;   // meter queue, wraps at 256
  localparam int unsigned BATCH_W   = 3;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CRED_W    = 5;   // binary credits, 0..20
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 3;

  localparam logic [CRED_W-1:0] CREDIT_CAP = 5'd20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B = 1'b1;

  typedef struct packed {
    logic coin_line_a;
    logic coin_line_b;
    logic slam_switch;
    logic bookkeep_enable;
  } in_item_t;

  typedef struct packed {
    logic [5:0] credit_count;
    logic       credit_changed;
    logic [1:0] meter_lines;
    logic [1:0] coin_chime;
    logic       slam_alarm;
    logic       slam_hold;
    logic [1:0] coin_ledger;
    logic [2:0] service_add_a;
    logic [2:0] service_add_b;
  } out_item_t;

  // Coinage pairs: coins per batch, credits per batch
  localparam logic [2:0] COINS_PER_BATCH [8] = '{
    3'd1, 3'd1, 3'd1, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1
  };
  localparam logic [2:0] BATCH_GRANT [8] = '{
    3'd2, 3'd3, 3'd5, 3'd5, 3'd4, 3'd3, 3'd1, 3'd1
  };

  // Saturating add of a batch onto the credit count
  function automatic logic [CRED_W-1:0] credit_add(input logic [CRED_W-1:0] c,
                                                   input logic [2:0] a);
    logic [CRED_W:0] sum;
    sum = {1'b0, c} + {3'b000, a};
    if (sum > {1'b0, CREDIT_CAP}) begin
      return CREDIT_CAP;
    end
    return sum[CRED_W-1:0];
  endfunction

  // Binary 0..20 to two BCD digits (tens digit trimmed to two bits)
  function automatic logic [5:0] credit_bcd(input logic [CRED_W-1:0] c);
    logic [1:0] tens;
    logic [CRED_W-1:0] ones;
    if (c >= 5'd20) begin
      tens = 2'd2;
      ones = c - 5'd20;
    end else if (c >= 5'd10) begin
      tens = 2'd1;
      ones = c - 5'd10;
    end else begin
      tens = 2'd0;
      ones = c;
    end
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

[rtl/core/ccst_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccst_if: valid/ready channels of the coin/credit service tick
// One interface for the tick samples, one for the per-tick results.
// ----------------------------------------------------------------------------
interface ccst_in_if;
  logic               valid;
  logic               ready;
  ccst_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccst_out_if;
  logic                valid;
  logic                ready;
  ccst_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/coin_credit_service_tick.sv]
`default_nettype none
// A result is registered as its tick is accepted, into the head or skid entry.
// Throughput: one tick per cycle while the skid entry is empty; the whole update is
//   one combinational pass from the state registers into the result register.
// A two-entry result buffer keeps input ready while one result waits.
// Reset (rst_n low, synchronous): credits, counters, queues and slam latch clear,
//   meter shadow goes to both bits set, coinage modes go to 0, buffer empties.
// ----------------------------------------------------------------------------
// coin_credit_service_tick: cabinet coin, slam and meter service
// Debounces coin lines, batches coins into BCD credits, handles the slam
// latch and drives the coin meter pulses, shared when both modes match.
// ----------------------------------------------------------------------------
module coin_credit_service_tick #(
  parameter int unsigned DEBOUNCE_TICKS = ccst_pkg::DEBOUNCE_TICKS_DEF,
  parameter int unsigned METER_PERIOD   = ccst_pkg::METER_PERIOD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ccst_in_if.sink                         in_ch,
  ccst_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ccst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccst_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import ccst_pkg::*;

  localparam logic [DEB_W-1:0] DEB_INIT  = DEB_W'(DEBOUNCE_TICKS);
  localparam logic [TMR_W-1:0] MET_INIT  = TMR_W'(METER_PERIOD);
  localparam logic [TMR_W-1:0] MET_HALF  = TMR_W'(METER_PERIOD / 2);

  // Configuration
  logic [MODE_W-1:0] mode_a_r, mode_b_r;

  // Service state
  logic [1:0]         prev_lines_r, prev_lines_nxt;
  logic               slam_r, slam_nxt;
  logic [DEB_W-1:0]   deb_r    [2];
  logic [DEB_W-1:0]   deb_nxt  [2];
  logic [QUEUE_W-1:0] queue_r  [2];
  logic [QUEUE_W-1:0] queue_nxt[2];
  logic [BATCH_W-1:0] batch_r  [2];
  logic [BATCH_W-1:0] batch_nxt[2];
  logic [TMR_W-1:0]   timer_r, timer_nxt;
  logic [1:0]         shadow_r, shadow_nxt;
  logic [CRED_W-1:0]  credits_r, credits_nxt;

  // Result buffer: head entry drives the port, skid catches a stalled result
  out_item_t head_r, skid_r, result;
  logic      head_vld_r, skid_vld_r;

  logic in_fire, out_fire;

  assign in_ch.ready  = ~skid_vld_r;
  assign in_fire      = in_ch.valid & ~skid_vld_r;
  assign out_ch.valid = head_vld_r;
  assign out_ch.data  = head_r;
  assign out_fire     = head_vld_r & out_ch.ready;

  // ---------------------------------------------------------------------------
  // One-tick update
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [1:0]         lines, edges, fire, full, chime, ledger;
    logic               hold, alarm, bk, arm;
    logic [DEB_W-1:0]   deb;
    logic [BATCH_W-1:0] bc, bc_inc;
    logic [MODE_W-1:0]  mode;
    logic [2:0]         add [2];
    logic [CRED_W-1:0]  c_slam, c_a;
    logic [TMR_W-1:0]   t;
    logic [1:0]         sh;
    logic [QUEUE_W-1:0] q0, q1;

    lines = {in_ch.data.coin_line_b, in_ch.data.coin_line_a};
    bk    = in_ch.data.bookkeep_enable;

    // Slam: first press latches, voids batches, debits one credit
    hold     = ~in_ch.data.slam_switch;
    alarm    = hold & ~slam_r;
    slam_nxt = slam_r | hold;

    // Any change on a coin line restarts its debounce
    edges          = lines ^ prev_lines_r;
    prev_lines_nxt = lines;

    for (int m = 0; m < 2; m++) begin
      deb         = edges[m] ? DEB_INIT : deb_r[m];
      deb_nxt[m]  = (deb != '0) ? deb - 1'b1 : '0;
      fire[m]     = (deb == DEB_W'(1)) & ~lines[m];
      mode        = (m == 0) ? mode_a_r : mode_b_r;
      bc          = alarm ? '0 : batch_r[m];
      bc_inc      = bc + 1'b1;
      full[m]     = fire[m] & (bc_inc >= COINS_PER_BATCH[mode]);
      batch_nxt[m] = fire[m] ? (full[m] ? '0 : bc_inc) : bc;
      ledger[m]   = fire[m] & bk;
      chime[m]    = fire[m];
      add[m]      = full[m] ? BATCH_GRANT[mode] : 3'd0;
    end

    // Credits: slam debit, then mechanism one batch, then mechanism two
    c_slam      = (alarm && credits_r != '0) ? credits_r - 1'b1 : credits_r;
    c_a         = credit_add(c_slam, add[0]);
    credits_nxt = credit_add(c_a, add[1]);

    // Meter pulses: bookkept coins queue first, then release at half
    // period or arm the next queued coin at zero
    t   = timer_r;
    sh  = shadow_r;
    q0  = ledger[0] ? queue_r[0] + 1'b1 : queue_r[0];
    q1  = ledger[1] ? queue_r[1] + 1'b1 : queue_r[1];
    arm = 1'b1;
    if (t != '0) begin
      t = t - 1'b1;
      if (t != '0) begin
        if (t == MET_HALF) begin
          sh = 2'b11;
        end
        arm = 1'b0;
      end
    end
    if (arm) begin
      if (q0 != '0) begin
        q0    = q0 - 1'b1;
        sh[0] = 1'b0;
        t     = MET_INIT;
      end
      if (q1 != '0) begin
        if (mode_a_r == mode_b_r) begin
          // shared meter line: waits if mechanism one just armed
          if (sh[0]) begin
            sh[0] = 1'b0;
            q1    = q1 - 1'b1;
            t     = MET_INIT;
          end
        end else begin
          sh[1] = 1'b0;
          q1    = q1 - 1'b1;
          t     = MET_INIT;
        end
      end
    end
    timer_nxt    = t;
    shadow_nxt   = sh;
    queue_nxt[0] = q0;
    queue_nxt[1] = q1;

    result.credit_count   = credit_bcd(credits_nxt);
    result.credit_changed = (alarm & (credits_r != '0)) | full[0] | full[1];
    result.meter_lines    = sh;
    result.coin_chime     = chime;
    result.slam_alarm     = alarm;
    result.slam_hold      = hold;
    result.coin_ledger    = ledger;
    result.service_add_a  = bk ? 3'd0 : add[0];
    result.service_add_b  = bk ? 3'd0 : add[1];
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_a_r <= '0;
      mode_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_A: mode_a_r <= cfg_wdata;
        CFG_MODE_B: mode_b_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lines_r <= '0;
      slam_r       <= 1'b0;
      deb_r        <= '{default: '0};
      queue_r      <= '{default: '0};
      batch_r      <= '{default: '0};
      timer_r      <= '0;
      shadow_r     <= 2'b11;
      credits_r    <= '0;
    end else if (in_fire) begin
      prev_lines_r <= prev_lines_nxt;
      slam_r       <= slam_nxt;
      deb_r        <= deb_nxt;
      queue_r      <= queue_nxt;
      batch_r      <= batch_nxt;
      timer_r      <= timer_nxt;
      shadow_r     <= shadow_nxt;
      credits_r    <= credits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        head_vld_r <= in_fire;
      end
    end else if (in_fire) begin
      if (head_vld_r) begin
        skid_vld_r <= 1'b1;
      end else begin
        head_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      head_r <= skid_vld_r ? skid_r : result;
    end else if (in_fire) begin
      if (head_vld_r) begin
        skid_r <= result;
      end else begin
        head_r <= result;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/ccst_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccst_checker: port-level checks for the coin/credit service tick
// Watches handshakes and result transactions; bound to the top level.
// ----------------------------------------------------------------------------
module ccst_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ccst_pkg::out_item_t out_data
);
  import ccst_pkg::*;

  // Credits never pass 20 and the ones digit stays a BCD digit
  a_credit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.credit_count <= 6'h20) && (out_data.credit_count[3:0] <= 4'd9))
    else $error("credit count out of BCD range");

  // A new slam alarm only comes with the switch pressed
  a_alarm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slam_alarm |-> out_data.slam_hold)
    else $error("slam alarm without slam hold");

  // Service add A only for an unbookkept, accepted coin that changed credits
  a_service_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.service_add_a != 3'd0) |->
      out_data.coin_chime[0] && !out_data.coin_ledger[0] && out_data.credit_changed)
    else $error("service credits without accepted coin");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input side is open right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind coin_credit_service_tick ccst_checker u_ccst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

[tb/ccst_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccst_result_checker: per-tick result prediction and compare
// Watches the tick and result channels plus the register write port, keeps
// its own model of the coin/slam/meter state and checks every result.
// ----------------------------------------------------------------------------
module ccst_result_checker #(
  parameter int unsigned DEBOUNCE_TICKS = 5,
  parameter int unsigned METER_PERIOD   = 50
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ccst_in_if                             in_ch,
  ccst_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [ccst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccst_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int unsigned                    outcomes_due,
  output int unsigned                    fault_count
);
  import ccst_pkg::*;

  // coinage pairs: coins needed per batch, credits granted per batch
  localparam int unsigned COINS_FOR_BATCH   [8] = '{1, 1, 1, 4, 3, 2, 2, 1};
  localparam int unsigned CREDITS_FOR_BATCH [8] = '{2, 3, 5, 5, 4, 3, 1, 1};
  localparam int unsigned CREDIT_LIMIT = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [2:0]  mode_a, mode_b;
  logic [1:0]  last_lines;
  logic        slam_seen;
  logic [2:0]  settle_cnt    [2];
  logic [7:0]  meter_backlog [2];
  logic [2:0]  batch_fill    [2];
  logic [5:0]  pulse_timer;
  logic [1:0]  meter_drive;
  int unsigned credit_total;   // binary, 0..20

  out_item_t   pending_outcomes [$];
  int unsigned results_seen;
  int unsigned faults;

  function automatic out_item_t run_service_tick(input in_item_t s);
    logic [1:0]  lines, edges;
    logic [2:0]  mode;
    logic        arm;
    int unsigned grant;
    out_item_t   r;
    r = '0;
    lines = {s.coin_line_b, s.coin_line_a};

    // slam: first press latches, voids batches, debits one credit
    if (!s.slam_switch) begin
      r.slam_hold = 1'b1;
      if (!slam_seen) begin
        slam_seen     = 1'b1;
        r.slam_alarm  = 1'b1;
        batch_fill[0] = '0;
        batch_fill[1] = '0;
        if (credit_total != 0) begin
          credit_total     = credit_total - 1;
          r.credit_changed = 1'b1;
        end
      end
    end

    edges      = lines ^ last_lines;
    last_lines = lines;
    for (int m = 0; m < 2; m++) begin
      if (edges[m]) settle_cnt[m] = 3'(DEBOUNCE_TICKS);
    end

    for (int m = 0; m < 2; m++) begin
      mode = (m == 0) ? mode_a : mode_b;
      if (settle_cnt[m] != 0) begin
        settle_cnt[m] = settle_cnt[m] - 3'd1;
        if (settle_cnt[m] == 0 && !lines[m]) begin
          if (s.bookkeep_enable) begin
            r.coin_ledger[m] = 1'b1;
            meter_backlog[m] = meter_backlog[m] + 8'd1;   // wraps at 256
          end
          r.coin_chime[m] = 1'b1;
          batch_fill[m]   = batch_fill[m] + 3'd1;
          if (batch_fill[m] >= COINS_FOR_BATCH[mode]) begin
            batch_fill[m] = '0;
            grant = CREDITS_FOR_BATCH[mode];
            if (!s.bookkeep_enable) begin
              if (m == 0) r.service_add_a = 3'(grant);
              else        r.service_add_b = 3'(grant);
            end
            credit_total = credit_total + grant;
            if (credit_total > CREDIT_LIMIT) credit_total = CREDIT_LIMIT;
            r.credit_changed = 1'b1;   // set even when capped
          end
        end
      end
    end

    // meter pulse: release at half period, arm next queued coin at zero
    arm = 1'b1;
    if (pulse_timer != 0) begin
      pulse_timer = pulse_timer - 6'd1;
      if (pulse_timer != 0) begin
        if (pulse_timer == 6'(METER_PERIOD / 2)) meter_drive = 2'b11;
        arm = 1'b0;
      end
    end
    if (arm) begin
      if (meter_backlog[0] != 0) begin
        meter_backlog[0] = meter_backlog[0] - 8'd1;
        meter_drive[0]   = 1'b0;
        pulse_timer      = 6'(METER_PERIOD);
      end
      if (meter_backlog[1] != 0) begin
        if (mode_a == mode_b) begin
          // shared meter: wait if mechanism one took it this tick
          if (meter_drive[0]) begin
            meter_drive[0]   = 1'b0;
            meter_backlog[1] = meter_backlog[1] - 8'd1;
            pulse_timer      = 6'(METER_PERIOD);
          end
        end else begin
          meter_drive[1]   = 1'b0;
          meter_backlog[1] = meter_backlog[1] - 8'd1;
          pulse_timer      = 6'(METER_PERIOD);
        end
      end
    end

    r.credit_count = 6'((credit_total / 10) * 16 + credit_total % 10);
    r.meter_lines  = meter_drive;
    return r;
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      note_fault($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                           results_seen, name, want, got));
    end
  endtask

  task automatic compare_outcome(input out_item_t want, input out_item_t got);
    check_field("credit_count",   8'(want.credit_count),   8'(got.credit_count));
    check_field("credit_changed", 8'(want.credit_changed), 8'(got.credit_changed));
    check_field("meter_lines",    8'(want.meter_lines),    8'(got.meter_lines));
    check_field("coin_chime",     8'(want.coin_chime),     8'(got.coin_chime));
    check_field("slam_alarm",     8'(want.slam_alarm),     8'(got.slam_alarm));
    check_field("slam_hold",      8'(want.slam_hold),      8'(got.slam_hold));
    check_field("coin_ledger",    8'(want.coin_ledger),    8'(got.coin_ledger));
    check_field("service_add_a",  8'(want.service_add_a),  8'(got.service_add_a));
    check_field("service_add_b",  8'(want.service_add_b),  8'(got.service_add_b));
  endtask

  initial begin
    results_seen = 0;
    faults       = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_a           = '0;
      mode_b           = '0;
      last_lines       = '0;
      slam_seen        = 1'b0;
      settle_cnt[0]    = '0;
      settle_cnt[1]    = '0;
      meter_backlog[0] = '0;
      meter_backlog[1] = '0;
      batch_fill[0]    = '0;
      batch_fill[1]    = '0;
      pulse_timer      = '0;
      meter_drive      = 2'b11;
      credit_total     = 0;
      pending_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE_A: mode_a = cfg_wdata;
          CFG_MODE_B: mode_b = cfg_wdata;
        endcase
      end
      // a result never shares an edge with its own tick, so pop first
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          note_fault($sformatf("result %0d arrived with nothing outstanding",
                               results_seen));
        end else begin
          compare_outcome(pending_outcomes.pop_front(), out_ch.data);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_outcomes.push_back(run_service_tick(in_ch.data));
      end
    end
    outcomes_due <= pending_outcomes.size();
    fault_count  <= faults;
  end

endmodule

[tb/coin_credit_service_tick_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coin_credit_service_tick_tb: coin/credit service tick testbench
// Drives cabinet samples through the tick channel with bursty timing, a
// randomly stalling result side and several coinage settings. The checker
// beside the block predicts every result; this module only makes stimulus
// and reports the verdict.
// ----------------------------------------------------------------------------
module coin_credit_service_tick_tb;
  import ccst_pkg::*;

  localparam int unsigned DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEF;
  localparam int unsigned METER_PERIOD   = METER_PERIOD_DEF;
  localparam int unsigned RANDOM_TICKS   = 640;
  localparam int unsigned PHASES         = 8;
  // fast coins on both lines to build a deep meter backlog
  localparam int unsigned FLOOD_TICKS    = 300;
  localparam int unsigned LONG_HOLD      = 80;    // receiver hold-off, cycles
  localparam int unsigned TAIL_CYCLES    = 10;

  // result-side stall behavior for one segment
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSED} rx_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  int unsigned          outcomes_due;
  int unsigned          fault_count;

  ccst_in_if  in_ch ();
  ccst_out_if out_ch ();

  coin_credit_service_tick #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
    .METER_PERIOD   (METER_PERIOD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ccst_result_checker #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS),
    .METER_PERIOD   (METER_PERIOD)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .outcomes_due (outcomes_due),
    .fault_count  (fault_count)
  );

  // sender burst state
  int unsigned burst_left;
  bit          eager;          // no gaps at all in this phase

  // coin line shaper: per mechanism, current level and ticks left at it
  bit [1:0]    line_lvl;
  int unsigned line_hold [2];
  int unsigned noise_left;
  bit          bk_level;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Offer one tick transaction and wait for its acceptance. Called at a
  // rising edge; returns at the edge the transaction was taken. Between
  // bursts valid drops for a random gap.
  task automatic issue(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // n identical ticks
  task automatic feed(input logic a, input logic b, input logic slam,
                      input logic bk, input int unsigned n);
    in_item_t it;
    it.coin_line_a     = a;
    it.coin_line_b     = b;
    it.slam_switch     = slam;
    it.bookkeep_enable = bk;
    repeat (n) issue(it);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  // The first edge lets the checker count the last accepted transaction.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outcomes_due != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed coin pulses: low for at least the debounce time,
  // with some short bounces that must be rejected. Now and then a stretch
  // of pure noise on lines and bookkeeping.
  task automatic shaped_item(output in_item_t it);
    if (noise_left == 0 && $urandom_range(0, 199) == 0) begin
      noise_left = $urandom_range(5, 30);
    end
    if ($urandom_range(0, 39) == 0) bk_level = ~bk_level;
    for (int m = 0; m < 2; m++) begin
      if (line_hold[m] == 0) begin
        line_lvl[m] = ~line_lvl[m];
        if (line_lvl[m] == 1'b0) begin
          line_hold[m] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, 10);
        end else begin
          line_hold[m] = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(1, 8);
        end
      end
      line_hold[m]--;
    end
    if (noise_left != 0) begin
      noise_left--;
      it.coin_line_a     = 1'($urandom_range(0, 1));
      it.coin_line_b     = 1'($urandom_range(0, 1));
      it.bookkeep_enable = 1'($urandom_range(0, 1));
    end else begin
      it.coin_line_a     = line_lvl[0];
      it.coin_line_b     = line_lvl[1];
      it.bookkeep_enable = bk_level;
    end
    // the latch is already set by now, so presses only raise the hold flag
    it.slam_switch = ($urandom_range(0, 49) != 0);
  endtask

  // Result side: segments of random stall style, plus a long hold-off
  // counted here so that the block's buffer fills and input ready drops.
  initial begin : receiver
    int unsigned cyc;
    int unsigned seg_left;
    int unsigned hold_left;
    rx_style_t   style;
    cyc       = 0;
    seg_left  = 0;
    hold_left = 0;
    style     = RX_OPEN;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      // the first such hold-off lands in the meter flood, where the
      // sender is busy
      if (cyc % 1000 == 250) hold_left = LONG_HOLD;
      if (seg_left == 0) begin
        style    = rx_style_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          RX_OPEN:  out_ch.ready <= 1'b1;
          RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:  out_ch.ready <= (cyc % 7 < 4);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] ma, mb;
    in_item_t             it;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_MODE_A;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    burst_left   = 0;
    eager        = 1'b0;
    line_lvl     = 2'b11;
    line_hold[0] = 0;
    line_hold[1] = 0;
    noise_left   = 0;
    bk_level     = 1'b1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: mechanism one needs four coins per batch, mechanism two
    // pays one credit per coin.
    write_mode(CFG_MODE_A, 3'd3);
    write_mode(CFG_MODE_B, 3'd7);
    feed(1, 1, 1, 1, 1);   // lines leave the reset value: debounce, no coin
    feed(0, 0, 1, 1, 5);   // both coins accepted, bookkept, queued to meters
    feed(1, 1, 1, 0, 1);
    feed(0, 0, 1, 0, 5);   // second coins, unbookkept: service credit on two
    feed(1, 1, 0, 0, 2);   // slam: alarm, partial batch voided, one credit off
                           // then a second press that only holds
    feed(0, 1, 1, 1, 3);   // bounce shorter than the debounce: rejected
    feed(1, 1, 1, 1, 1);
    feed(0, 0, 1, 1, 5);   // coins after the slam start a fresh batch
    settle();

    // Meter flood: fastest legal coin rate on both lines with bookkeeping,
    // modes differ so both meters arm on every pulse.
    write_mode(CFG_MODE_A, 3'd2);
    write_mode(CFG_MODE_B, 3'd5);
    for (int unsigned k = 0; k < FLOOD_TICKS; k++) begin
      feed(k % 6 == 5, k % 6 == 5, 1, 1, 1);
    end
    settle();

    // Random phases over several coinage settings, extremes and equal
    // modes (shared meter) among them. Each phase ends fully drained.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin ma = 3'd0; mb = 3'd0; end
        1:       begin ma = 3'd7; mb = 3'd7; end
        2:       begin ma = 3'd3; mb = 3'd6; end
        3:       begin ma = 3'd7; mb = 3'd0; end
        4:       begin ma = 3'd0; mb = 3'd7; end
        5:       begin ma = 3'd2; mb = 3'd2; end
        default: begin
          ma = 3'($urandom_range(0, 7));
          mb = ($urandom_range(0, 1) == 0) ? ma : 3'($urandom_range(0, 7));
        end
      endcase
      write_mode(CFG_MODE_A, ma);
      write_mode(CFG_MODE_B, mb);
      eager = (ph % 3 == 2);
      repeat (RANDOM_TICKS / PHASES) begin
        shaped_item(it);
        issue(it);
      end
      settle();
    end

    // quiet tail to catch any stray result transaction
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[coin_credit_service_tick.f]
rtl/core/ccst_pkg.sv
rtl/core/ccst_if.sv
rtl/core/coin_credit_service_tick.sv
rtl/core/ccst_checker.sv
tb/ccst_result_checker.sv
tb/coin_credit_service_tick_tb.sv
